### sv/cpdr_pkg.sv
// shared types, constants and crc functions of the chain packet deframer/router
`default_nettype none

package cpdr_pkg;

  localparam int unsigned MAX_BODY_BYTES_DEF = 4096;

  localparam logic [15:0] CRC_SEED_RST = 16'h1D0F;
  localparam logic [15:0] CRC_POLY     = 16'h1021;
  localparam logic [15:0] NODE_ID_RST  = 16'hFFFF;

  // magic words as they sit on the bus, first byte in the low bits
  localparam logic [31:0] MAGIC_CTRL = 32'h6F69_7841;
  localparam logic [31:0] MAGIC_ENUM = 32'h6D75_6E45;
  localparam logic [31:0] MAGIC_RESP = 32'h7073_6552;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned IN_TDATA_W = 32;
  localparam int unsigned IN_TUSER_W = 1;
  localparam int unsigned RES_W      = 99;
  localparam int unsigned OUT_TDATA_W = 104;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CRC_SEED     = 1'b0,
    CFG_CHAIN_MASTER = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PH_MAGIC  = 2'd0,
    PH_HEADER = 2'd1,
    PH_BODY   = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    KIND_CTRL = 2'd0,
    KIND_ENUM = 2'd1,
    KIND_RESP = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    ST_FORWARD   = 4'd0,
    ST_DLV_CTRL  = 4'd1,
    ST_DLV_RESP  = 4'd2,
    ST_CONSUMED  = 4'd3,
    ST_CRC_ERR   = 4'd4,
    ST_BAD_MAGIC = 4'd5,
    ST_TOO_LONG  = 4'd6,
    ST_UNALIGNED = 4'd7,
    ST_TIMEOUT   = 4'd8
  } status_e;

  typedef enum logic {
    OP_DATA    = 1'b0,
    OP_TIMEOUT = 1'b1
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [31:0] word;
  } item_t;

  typedef struct packed {
    logic [31:0] crc_errs;
    logic [15:0] own_id;     // signed
    logic [15:0] fwd_cksum;
    logic [15:0] fwd_id;     // signed
    logic [12:0] body_len;
    logic [1:0]  kind;
    status_e     status;
  } res_t;

  // one byte through the crc register, msb first
  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      r = r[15] ? ({r[14:0], 1'b0} ^ CRC_POLY) : {r[14:0], 1'b0};
    end
    return r;
  endfunction

  // four bytes, low byte first; linear, so it folds into a flat xor tree
  function automatic logic [15:0] crc_word(input logic [15:0] c, input logic [31:0] w);
    logic [15:0] r;
    r = crc_byte(c, w[7:0]);
    r = crc_byte(r, w[15:8]);
    r = crc_byte(r, w[23:16]);
    r = crc_byte(r, w[31:24]);
    return r;
  endfunction

endpackage

`default_nettype wire

### sv/cpdr_in_reg.sv
// input register stage holding one accepted word
`default_nettype none

module cpdr_in_reg (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          vld_i,
  output logic               rdy_o,
  input  wire cpdr_pkg::item_t item_i,
  input  wire logic          pop_i,
  output logic               vld_o,
  output cpdr_pkg::item_t    item_o
);
  import cpdr_pkg::*;

  logic  vld_q;
  item_t item_q;

  assign rdy_o  = !vld_q || pop_i;
  assign vld_o  = vld_q;
  assign item_o = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (rdy_o) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_o && vld_i) begin
      item_q <= item_i;
    end
  end

endmodule

`default_nettype wire

### sv/cpdr_core.sv
// framing state, crc registers and routing decision
`default_nettype none

module cpdr_core #(
  parameter int unsigned MAX_BODY_BYTES = cpdr_pkg::MAX_BODY_BYTES_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [cpdr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [cpdr_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                            in_vld_i,
  input  wire cpdr_pkg::item_t                 item_i,
  input  wire logic                            out_free_i,
  output logic                                 adv_o,
  output logic                                 res_vld_o,
  output cpdr_pkg::res_t                       res_o
);
  import cpdr_pkg::*;

  localparam logic [15:0] MaxLen = 16'(MAX_BODY_BYTES);

  logic [15:0] crc_seed_q;
  logic        master_q;

  phase_e      phase_q, phase_d;
  logic [1:0]  kind_q, kind_d;
  logic [12:0] len_q, len_d;
  logic [12:0] rem_q, rem_d;
  logic [15:0] hck_q, hck_d;
  logic [15:0] crc_p_q, crc_p_d;
  logic [15:0] crc_a_q, crc_a_d;
  logic [15:0] fh_q, fh_d;
  logic [15:0] rep_q, rep_d;
  logic [15:0] node_id_q, node_id_d;
  logic [31:0] errs_q, errs_d;

  logic        adv, is_tout, magic_ok, len_bad, body_live, body_end, first_word;
  logic [31:0] w;
  logic [15:0] hw, len16, eff_id, rep_new, fh_cur, rep_cur, crc_p_new, crc_a_new;
  logic [12:0] rem_dec;
  logic [1:0]  magic_kind;

  assign adv     = in_vld_i && out_free_i;
  assign adv_o   = adv;
  assign w       = item_i.word;
  assign is_tout = (item_i.op == OP_TIMEOUT);
  assign hw      = w[15:0];
  assign len16   = w[15:0];
  assign eff_id  = master_q ? 16'h0000 : node_id_q;

  always_comb begin
    magic_ok   = 1'b1;
    magic_kind = KIND_CTRL;
    unique case (w)
      MAGIC_CTRL: magic_kind = KIND_CTRL;
      MAGIC_ENUM: magic_kind = KIND_ENUM;
      MAGIC_RESP: magic_kind = KIND_RESP;
      default:    magic_ok   = 1'b0;
    endcase
  end

  assign len_bad    = (len16 > MaxLen) || (len16[1:0] != 2'b00);
  assign body_live  = (rem_q != '0);
  assign rem_dec    = rem_q - 13'd4;
  assign body_end   = body_live && (rem_dec == '0);
  assign first_word = (rem_q == len_q);

  // replacement id for the first body halfword
  always_comb begin
    if (eff_id[15]) begin
      rep_new = hw + 16'd1;
    end else if (eff_id != '0) begin
      rep_new = eff_id + 16'd1;
    end else begin
      rep_new = hw;
    end
  end

  assign fh_cur    = first_word ? hw : fh_q;
  assign rep_cur   = first_word ? rep_new : rep_q;
  assign crc_p_new = crc_word(crc_p_q, w);
  assign crc_a_new = crc_word(crc_a_q, first_word ? {w[31:16], rep_new} : w);

  // next phase
  always_comb begin
    phase_d = phase_q;
    if (adv) begin
      if (is_tout) begin
        phase_d = PH_MAGIC;
      end else begin
        unique case (phase_q)
          PH_MAGIC:  phase_d = magic_ok ? PH_HEADER : PH_MAGIC;
          PH_HEADER: phase_d = len_bad ? PH_MAGIC : PH_BODY;
          PH_BODY:   phase_d = body_end ? PH_MAGIC : PH_BODY;
          default:   phase_d = PH_MAGIC;
        endcase
      end
    end
  end

  // packet registers and result
  always_comb begin
    logic clr;
    clr       = 1'b0;
    kind_d    = kind_q;
    len_d     = len_q;
    rem_d     = rem_q;
    hck_d     = hck_q;
    crc_p_d   = crc_p_q;
    crc_a_d   = crc_a_q;
    fh_d      = fh_q;
    rep_d     = rep_q;
    node_id_d = node_id_q;
    errs_d    = errs_q;
    res_vld_o = 1'b0;
    res_o     = '0;
    res_o.status = ST_FORWARD;

    if (adv) begin
      if (is_tout) begin
        if (phase_q != PH_MAGIC) begin
          res_vld_o       = 1'b1;
          res_o.status    = ST_TIMEOUT;
          res_o.kind      = kind_q;
          res_o.body_len  = len_q;
          clr             = 1'b1;
        end
      end else begin
        unique case (phase_q)
          PH_MAGIC: begin
            if (magic_ok) begin
              kind_d = magic_kind;
            end else begin
              res_vld_o    = 1'b1;
              res_o.status = ST_BAD_MAGIC;
              clr          = 1'b1;
            end
          end
          PH_HEADER: begin
            if (len_bad) begin
              res_vld_o    = 1'b1;
              res_o.status = (len16 > MaxLen) ? ST_TOO_LONG : ST_UNALIGNED;
              res_o.kind   = kind_q;
              clr          = 1'b1;
            end else begin
              len_d   = len16[12:0];
              rem_d   = len16[12:0];
              hck_d   = w[31:16];
              crc_p_d = crc_seed_q;
              crc_a_d = crc_seed_q;
            end
          end
          PH_BODY: begin
            if (body_live) begin
              fh_d    = fh_cur;
              rep_d   = rep_cur;
              crc_p_d = crc_p_new;
              crc_a_d = crc_a_new;
              rem_d   = rem_dec;
              if (body_end) begin
                res_vld_o      = 1'b1;
                res_o.kind     = kind_q;
                res_o.body_len = len_q;
                clr            = 1'b1;
                if (hck_q != crc_p_new) begin
                  errs_d       = errs_q + 32'd1;
                  res_o.status = ST_CRC_ERR;
                end else begin
                  case (kind_q)
                    KIND_ENUM: begin
                      if (!fh_cur[15] && fh_cur != '0 && eff_id != '0) begin
                        if (eff_id[15]) begin
                          node_id_d = fh_cur;
                        end
                        res_o.status    = ST_FORWARD;
                        res_o.fwd_id    = rep_cur;
                        res_o.fwd_cksum = crc_a_new;
                      end else begin
                        res_o.status = ST_CONSUMED;
                      end
                    end
                    KIND_RESP: begin
                      if (!eff_id[15] && eff_id != '0) begin
                        res_o.status    = ST_FORWARD;
                        res_o.fwd_id    = fh_cur;
                        res_o.fwd_cksum = hck_q;
                      end else begin
                        res_o.status = ST_DLV_RESP;
                      end
                    end
                    default: begin
                      if (eff_id[15]) begin
                        res_o.status = ST_CONSUMED;
                      end else if (fh_cur != eff_id) begin
                        res_o.status    = ST_FORWARD;
                        res_o.fwd_id    = fh_cur;
                        res_o.fwd_cksum = hck_q;
                      end else begin
                        res_o.status = ST_DLV_CTRL;
                      end
                    end
                  endcase
                end
              end
            end
          end
          default: ;
        endcase
      end
    end

    if (clr) begin
      kind_d  = KIND_CTRL;
      len_d   = '0;
      rem_d   = '0;
      hck_d   = '0;
      crc_p_d = crc_seed_q;
      crc_a_d = crc_seed_q;
      fh_d    = '0;
      rep_d   = '0;
    end
    res_o.own_id   = master_q ? 16'h0000 : node_id_d;
    res_o.crc_errs = errs_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_seed_q <= CRC_SEED_RST;
      master_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CRC_SEED:     crc_seed_q <= cfg_wdata_i;
        CFG_CHAIN_MASTER: master_q   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_MAGIC;
      kind_q    <= KIND_CTRL;
      len_q     <= '0;
      rem_q     <= '0;
      hck_q     <= '0;
      crc_p_q   <= CRC_SEED_RST;
      crc_a_q   <= CRC_SEED_RST;
      fh_q      <= '0;
      rep_q     <= '0;
      node_id_q <= NODE_ID_RST;
      errs_q    <= '0;
    end else begin
      phase_q   <= phase_d;
      kind_q    <= kind_d;
      len_q     <= len_d;
      rem_q     <= rem_d;
      hck_q     <= hck_d;
      crc_p_q   <= crc_p_d;
      crc_a_q   <= crc_a_d;
      fh_q      <= fh_d;
      rep_q     <= rep_d;
      node_id_q <= node_id_d;
      errs_q    <= errs_d;
    end
  end

  a_rem_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q[1:0] == 2'b00 && rem_q <= len_q)
    else $error("remaining byte count out of step with length");

  a_crc_err_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && res_vld_o && res_o.status == ST_CRC_ERR |=> errs_q == $past(errs_q) + 32'd1)
    else $error("crc error not counted");

  a_fwd_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_o && res_o.status != ST_FORWARD |-> res_o.fwd_id == '0 && res_o.fwd_cksum == '0)
    else $error("forward fields set on a non-forward result");

  a_body_end_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && !is_tout && phase_q == PH_BODY && body_end |=> phase_q == PH_MAGIC && rem_q == '0)
    else $error("packet not cleared at end of body");

endmodule

`default_nettype wire

### sv/cpdr_out_reg.sv
// result register in front of the output stream
`default_nettype none

module cpdr_out_reg (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             ld_i,
  input  wire cpdr_pkg::res_t                   res_i,
  output logic                                  free_o,
  output logic                                  vld_o,
  input  wire logic                             rdy_i,
  output logic [cpdr_pkg::OUT_TDATA_W-1:0]      tdata_o
);
  import cpdr_pkg::*;

  logic vld_q;
  res_t res_q;

  assign free_o  = !vld_q || rdy_i;
  assign vld_o   = vld_q;
  assign tdata_o = {{(OUT_TDATA_W-RES_W){1'b0}}, res_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (free_o) begin
      vld_q <= ld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && ld_i) begin
      res_q <= res_i;
    end
  end

endmodule

`default_nettype wire

### sv/chain_packet_deframer_router.sv
// top level of the chain packet deframer and router
// a word accepted into the input register is decided combinationally by the core,
//   and its result word is loaded into the result register when the core steps
// throughput: one word per cycle while the result register is free; the crc word
//   update and the routing decision sit in the single stage between the two registers
// reset (rst_ni, async low): framing back to magic search, node id -1, error
//   count zero, crc seed 0x1d0f, chain master off; no pending words
`default_nettype none

module chain_packet_deframer_router #(
  parameter int unsigned MAX_BODY_BYTES = cpdr_pkg::MAX_BODY_BYTES_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // configuration write port
  input  wire logic                               cfg_we_i,
  input  wire logic [cpdr_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [cpdr_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  // input stream
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  wire logic [cpdr_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // data_word
  input  wire logic [cpdr_pkg::IN_TUSER_W-1:0]    s_axis_tuser,  // opcode
  // result stream
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // status[3:0] packet_kind[5:4] body_length[18:6] forward_id[34:19]
  // forward_checksum[50:35] own_id[66:51] crc_error_count[98:67], zero pad
  output logic [cpdr_pkg::OUT_TDATA_W-1:0]        m_axis_tdata
);
  import cpdr_pkg::*;

  item_t in_item, reg_item;
  logic  reg_vld, adv, out_free, res_vld;
  res_t  res;

  // tuser carries the opcode, tdata the four bytes
  assign in_item.op   = op_e'(s_axis_tuser[0]);
  assign in_item.word = s_axis_tdata;

  // input register: frees itself when the core takes its word
  cpdr_in_reg u_in_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (s_axis_tvalid),
    .rdy_o  (s_axis_tready),
    .item_i (in_item),
    .pop_i  (adv),
    .vld_o  (reg_vld),
    .item_o (reg_item)
  );

  // framing, crc and routing decision; steps only when the result slot is free
  cpdr_core #(
    .MAX_BODY_BYTES (MAX_BODY_BYTES)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_vld_i    (reg_vld),
    .item_i      (reg_item),
    .out_free_i  (out_free),
    .adv_o       (adv),
    .res_vld_o   (res_vld),
    .res_o       (res)
  );

  // result register: words that give no result just pass through the core
  cpdr_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ld_i    (adv && res_vld),
    .res_i   (res),
    .free_o  (out_free),
    .vld_o   (m_axis_tvalid),
    .rdy_i   (m_axis_tready),
    .tdata_o (m_axis_tdata)
  );

endmodule

`default_nettype wire
